// ===== sv/mfps_pkg.sv =====
// ----------------------------------------------------------------------------
// mfps_pkg
// Shared types and constants for the minimum falling path sum block.
// ----------------------------------------------------------------------------
package mfps_pkg;

   localparam int CELL_W     = 16;
   localparam int SUM_W      = 32;
   localparam int COLS_W     = 9;
   localparam int ROWS_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [CELL_W-1:0]     cell_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic [CSR_IDX_W-1:0]         csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]        csr_data_type;

   // register indexes
   localparam csr_idx_type CSR_NUM_COLS = 2'd0;
   localparam csr_idx_type CSR_NUM_ROWS = 2'd1;

   localparam sum_type SUM_MAX = 32'sh7FFF_FFFF;
   localparam sum_type SUM_MIN = 32'sh8000_0000;

   // position flags of one item within the grid
   typedef struct packed {
      logic first_row;
      logic last_col;
      logic last_row;
      logic emit;       // last cell of the grid
   } cell_tag_type;

endpackage

// ===== sv/mfps_ram.sv =====
// ----------------------------------------------------------------------------
// mfps_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mfps_seq.sv =====
// ----------------------------------------------------------------------------
// mfps_seq
// Configuration registers, row/column counters and line store read addressing.
// ----------------------------------------------------------------------------
module mfps_seq #(
   parameter int MAX_COLS = 256
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_valid,
   input  mfps_pkg::csr_idx_type                         csr_index,
   input  mfps_pkg::csr_data_type                        csr_data,
   input  logic                                          accept,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] cell_col,
   output mfps_pkg::cell_tag_type                        cell_tag,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rd_addr
);
   import mfps_pkg::*;

   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int NCW = $clog2(MAX_COLS + 1);
   localparam int XW  = ((NCW > COLS_W) ? NCW : COLS_W) + 1;

   logic [COLS_W-1:0] num_cols_ff, num_cols_in;
   logic [ROWS_W-1:0] num_rows_ff, num_rows_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [ROWS_W-1:0] row_ff, row_in;

   logic [XW-1:0]     ncols_x;
   logic [XW-1:0]     c_x;
   logic [ROWS_W-1:0] nrows;
   logic              last_col;
   logic              last_row;

   always_comb begin
      // effective column count: zero acts as one, clamp to store depth
      if (num_cols_ff == '0) begin
         ncols_x = XW'(1);
      end else if (XW'(num_cols_ff) > XW'(MAX_COLS)) begin
         ncols_x = XW'(MAX_COLS);
      end else begin
         ncols_x = XW'(num_cols_ff);
      end
      nrows = (num_rows_ff == '0) ? ROWS_W'(1) : num_rows_ff;

      c_x = XW'(col_ff);
      if (c_x >= ncols_x) begin
         c_x = ncols_x - XW'(1);
      end
      last_col = (c_x + XW'(1)) >= ncols_x;
      last_row = ({1'b0, row_ff} + (ROWS_W+1)'(1)) >= {1'b0, nrows};

      cell_col           = c_x[CW-1:0];
      cell_tag.first_row = (row_ff == '0);
      cell_tag.last_col  = last_col;
      cell_tag.last_row  = last_row;
      cell_tag.emit      = last_col && last_row;

      // fetch the entry the next item needs: next column, or column 0 at row end
      rd_addr = last_col ? '0 : CW'(c_x + XW'(1));

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!last_col) begin
            col_in = CW'(c_x + XW'(1));
         end else begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROWS_W'(1);
         end
      end

      num_cols_in = num_cols_ff;
      num_rows_in = num_rows_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_COLS: num_cols_in = csr_data[COLS_W-1:0];
            CSR_NUM_ROWS: num_rows_in = csr_data[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= COLS_W'(1);
         num_rows_ff <= ROWS_W'(1);
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         num_cols_ff <= num_cols_in;
         num_rows_ff <= num_rows_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

endmodule

// ===== sv/min_falling_path_sum.sv =====
// ----------------------------------------------------------------------------
// min_falling_path_sum
// Streaming minimum falling path sum over a grid given in row-major order.
// ----------------------------------------------------------------------------
// Cells are taken one per clock unless held as described below. Each accepted
// cell reads one line store entry (the next column's best sum of the row above,
// or column 0 at a row end); in the next cycle the cell adds its value to the
// minimum of up to three best sums and writes its own best sum back. The line
// store has one read and one write port, which sets the rate at one cell per
// cycle. The result of a grid is registered from the compute stage of its final
// cell into a two-entry result buffer; the final cell of a grid also waits while
// that buffer, with any result still finishing, would stay full. Each register
// write holds the input while the current column's entry is fetched again.
// num_cols above MAX_COLS acts as MAX_COLS; a zero count acts as one.
module min_falling_path_sum #(
   parameter int MAX_COLS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mfps_pkg::cell_type      req_cell_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mfps_pkg::sum_type       rsp_min_sum,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  mfps_pkg::csr_idx_type   csr_index,
   input  mfps_pkg::csr_data_type  csr_data
);
   import mfps_pkg::*;

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic          accept;
   logic [CW-1:0] cell_col;
   cell_tag_type  cell_tag;
   logic [CW-1:0] rd_addr;
   sum_type       rd_data;
   logic [CW-1:0] line_rd_addr;
   logic          line_rd_en;

   // compute stage
   logic          s1_valid_ff;
   cell_tag_type  s1_tag_ff;
   logic [CW-1:0] s1_col_ff;
   cell_type      s1_value_ff;
   logic          s1_fwd_hit_ff;
   sum_type       s1_fwd_data_ff;
   logic          s1_emit;

   // entry refetch after a register write
   logic          refetch_ff;
   logic          reload_ff;

   sum_type       cur_old_ff, cur_old_in;
   sum_type       left_ff, left_in;
   sum_type       run_min_ff, run_min_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sum_type       rsp_min_sum_ff, rsp_min_sum_in;
   logic          spare_valid_ff, spare_valid_in;
   sum_type       spare_sum_ff, spare_sum_in;
   logic          rsp_pop;
   logic [1:0]    held_cnt;

   sum_type           nxt_old;
   sum_type           m;
   logic signed [SUM_W:0] sum_x;
   sum_type           best;
   sum_type           cand;

   mfps_seq #(
      .MAX_COLS (MAX_COLS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .cell_col  (cell_col),
      .cell_tag  (cell_tag),
      .rd_addr   (rd_addr)
   );

   mfps_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_COLS)
   ) u_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (best),
      .rd_en   (line_rd_en),
      .rd_addr (line_rd_addr),
      .rd_data (rd_data)
   );

   assign csr_ready = 1'b1;

   // a column count change can move the current column; fetch its entry again
   assign line_rd_en   = accept || refetch_ff;
   assign line_rd_addr = refetch_ff ? cell_col : rd_addr;

   assign s1_emit  = s1_valid_ff && s1_tag_ff.emit;
   assign rsp_pop  = rsp_valid_ff && rsp_ready;
   // results held after this edge
   assign held_cnt = 2'(rsp_valid_ff) + 2'(spare_valid_ff) + 2'(s1_emit) - 2'(rsp_pop);

   // the last cell of a grid needs a free result slot when it finishes
   assign req_ready = !refetch_ff && !(cell_tag.emit && (held_cnt >= 2'd2));
   assign accept    = req_valid && req_ready;

   always_comb begin
      // a read issued while the same entry was being written gets the new value
      nxt_old = s1_fwd_hit_ff ? s1_fwd_data_ff : rd_data;

      m = cur_old_ff;
      if (s1_col_ff != '0 && left_ff < m) begin
         m = left_ff;
      end
      if (!s1_tag_ff.last_col && nxt_old < m) begin
         m = nxt_old;
      end

      sum_x = (SUM_W+1)'(m) + (SUM_W+1)'(s1_value_ff);
      if (s1_tag_ff.first_row) begin
         best = SUM_W'(s1_value_ff);
      end else if (sum_x[SUM_W] != sum_x[SUM_W-1]) begin
         best = sum_x[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         best = sum_x[SUM_W-1:0];
      end

      cand = (best < run_min_ff) ? best : run_min_ff;

      cur_old_in     = cur_old_ff;
      left_in        = left_ff;
      run_min_in     = run_min_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_min_sum_in = rsp_min_sum_ff;
      spare_valid_in = spare_valid_ff;
      spare_sum_in   = spare_sum_ff;
      if (rsp_pop) begin
         rsp_valid_in   = spare_valid_ff;
         rsp_min_sum_in = spare_sum_ff;
         spare_valid_in = 1'b0;
      end
      if (s1_valid_ff) begin
         left_in = cur_old_ff;
         // single-column rows read back their own result
         cur_old_in = (s1_tag_ff.last_col && s1_col_ff == '0) ? best : nxt_old;
         if (s1_tag_ff.last_row) begin
            run_min_in = cand;
         end
         if (s1_tag_ff.emit) begin
            run_min_in = SUM_MAX;
            if (rsp_valid_in) begin
               spare_valid_in = 1'b1;
               spare_sum_in   = cand;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_min_sum_in = cand;
            end
         end
      end else if (reload_ff) begin
         cur_old_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
         refetch_ff     <= 1'b0;
         reload_ff      <= 1'b0;
         run_min_ff     <= SUM_MAX;
         cur_old_ff     <= '0;
         left_ff        <= '0;
      end else begin
         s1_valid_ff    <= accept;
         rsp_valid_ff   <= rsp_valid_in;
         spare_valid_ff <= spare_valid_in;
         refetch_ff     <= csr_valid && csr_ready;
         reload_ff      <= refetch_ff;
         run_min_ff     <= run_min_in;
         cur_old_ff     <= cur_old_in;
         left_ff        <= left_in;
      end
      if (accept) begin
         s1_tag_ff      <= cell_tag;
         s1_col_ff      <= cell_col;
         s1_value_ff    <= req_cell_value;
         s1_fwd_hit_ff  <= s1_valid_ff && (s1_col_ff == rd_addr);
         s1_fwd_data_ff <= best;
      end
      rsp_min_sum_ff <= rsp_min_sum_in;
      spare_sum_ff   <= spare_sum_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_min_sum = rsp_min_sum_ff;

   // compute stage only ever follows an accepted item
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(req_valid && req_ready))
      else $error("compute stage active without an accepted item");

   // a finishing grid never overwrites an unread result
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_tag_ff.emit) |-> (!spare_valid_ff || rsp_ready))
      else $error("result buffer overrun");

   // a new result only comes from the last cell of a grid
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_tag_ff.emit))
      else $error("result raised without a finished grid");

endmodule
